### hdl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, widths and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int LEN_W  = 3;
   localparam int PEND_W = 2;

   localparam logic [CP_W-1:0]  CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [LEN_W-1:0] LEN_ONE        = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO        = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE      = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR       = 3'd4;

   // Byte class seen while no sequence is open
   typedef enum logic [4:0] {
      LEAD_ASCII = 5'b00001,
      LEAD_TWO   = 5'b00010,
      LEAD_THREE = 5'b00100,
      LEAD_FOUR  = 5'b01000,
      LEAD_BAD   = 5'b10000
   } lead_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
      logic             replaced;
   } result_type;

   function automatic lead_type classify_lead(input logic [BYTE_W-1:0] b);
      lead_type cls;
      priority if (b < 8'h80)                   cls = LEAD_ASCII;
      else if (b >= 8'hC2 && b <= 8'hDF)       cls = LEAD_TWO;
      else if (b >= 8'hE0 && b <= 8'hEF)       cls = LEAD_THREE;
      else if (b >= 8'hF0 && b <= 8'hF4)       cls = LEAD_FOUR;
      else                                     cls = LEAD_BAD;
      return cls;
   endfunction

endpackage

### hdl/u8d_in_stage.sv
// ----------------------------------------------------------------------------
// u8d_in_stage
// Input register: captures one byte item whenever the stage is empty or
// its current item moves on to the decode step.
// ----------------------------------------------------------------------------
module u8d_in_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [u8d_pkg::BYTE_W-1:0]  req_in_byte,
   output logic                        req_stall,
   input  logic                        take,
   output logic                        s_valid,
   output logic [u8d_pkg::BYTE_W-1:0]  s_byte
);
   import u8d_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              load;

   assign load      = !valid_ff || take;
   assign req_stall = !load;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = req_valid;
         if (req_valid) begin
            byte_in = req_in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign s_valid = valid_ff;
   assign s_byte  = byte_ff;

endmodule

### hdl/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode
// Decoder state (pending count, partial code point, sequence length) and
// the one-byte update step.
// ----------------------------------------------------------------------------
module u8d_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [u8d_pkg::BYTE_W-1:0]  in_byte,
   output logic                        emit,
   output u8d_pkg::result_type         result
);
   import u8d_pkg::*;

   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [CP_W-1:0]   pv_ff, pv_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   always_comb begin
      pend_in           = pend_ff;
      pv_in             = pv_ff;
      len_in            = len_ff;
      emit              = 1'b0;
      result.code_point = '0;
      result.seq_length = LEN_ONE;
      result.replaced   = 1'b0;
      if (pend_ff != '0) begin
         // any byte counts as continuation here, low six bits only
         pv_in   = {pv_ff[CP_W-7:0], in_byte[5:0]};
         pend_in = pend_ff - 2'd1;
         if (pend_ff == 2'd1) begin
            emit              = 1'b1;
            result.code_point = pv_in;
            result.seq_length = len_ff;
         end
      end else begin
         unique case (classify_lead(in_byte))
            LEAD_ASCII: begin
               len_in            = LEN_ONE;
               pv_in             = '0;
               emit              = 1'b1;
               result.code_point = CP_W'(in_byte);
            end
            LEAD_TWO: begin
               pv_in   = CP_W'(in_byte[4:0]);
               pend_in = 2'd1;
               len_in  = LEN_TWO;
            end
            LEAD_THREE: begin
               pv_in   = CP_W'(in_byte[3:0]);
               pend_in = 2'd2;
               len_in  = LEN_THREE;
            end
            LEAD_FOUR: begin
               pv_in   = CP_W'(in_byte[2:0]);
               pend_in = 2'd3;
               len_in  = LEN_FOUR;
            end
            default: begin
               len_in            = LEN_ONE;
               pv_in             = '0;
               emit              = 1'b1;
               result.code_point = CP_REPLACEMENT;
               result.replaced   = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         pv_ff   <= '0;
         len_ff  <= LEN_ONE;
      end else if (step) begin
         pend_ff <= pend_in;
         pv_ff   <= pv_in;
         len_ff  <= len_in;
      end
   end

   // open sequence: length covers the bytes still expected
   a_len_vs_pend: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0) |-> (len_ff > LEN_W'(pend_ff)) && (len_ff <= LEN_FOUR))
      else $error("sequence length inconsistent with pending count");

   a_close_on_last: assert property (@(posedge clock) disable iff (reset)
      (step && pend_ff == 2'd1) |=> (pend_ff == '0))
      else $error("sequence not closed after last continuation");

   a_replace_only_idle: assert property (@(posedge clock) disable iff (reset)
      result.replaced |-> (pend_ff == '0))
      else $error("replacement raised inside an open sequence");

endmodule

### hdl/u8d_out_stage.sv
// ----------------------------------------------------------------------------
// u8d_out_stage
// Result register: holds a decoded item until the consumer takes it and
// tells the upstream stages when they may advance.
// ----------------------------------------------------------------------------
module u8d_out_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        s_valid,
   input  logic                        emit,
   input  u8d_pkg::result_type         result,
   output logic                        advance,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [u8d_pkg::CP_W-1:0]    rsp_code_point,
   output logic [u8d_pkg::LEN_W-1:0]   rsp_seq_length,
   output logic                        rsp_replaced
);
   import u8d_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = s_valid && emit;
         if (s_valid && emit) begin
            data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_code_point = data_ff.code_point;
   assign rsp_seq_length = data_ff.seq_length;
   assign rsp_replaced   = data_ff.replaced;

endmodule

### hdl/utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// UTF-8 byte stream decoder, one byte per item, one code point per result.
// Path: input register, combinational decode step, then result register;
// a stalled result register holds the byte in the input register.
// Takes 1 byte per cycle while the result register is not stalled.
// Synchronous active-high reset empties both stages and closes any open
// sequence (pending 0, length 1).
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [u8d_pkg::BYTE_W-1:0]  req_in_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [u8d_pkg::CP_W-1:0]    rsp_code_point,
   output logic [u8d_pkg::LEN_W-1:0]   rsp_seq_length,
   output logic                        rsp_replaced
);
   import u8d_pkg::*;

   logic              s_valid;
   logic [BYTE_W-1:0] s_byte;
   logic              advance;
   logic              step;
   logic              emit;
   result_type        result;

   assign step = s_valid && advance;

   u8d_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_stall   (req_stall),
      .take        (advance),
      .s_valid     (s_valid),
      .s_byte      (s_byte)
   );

   u8d_decode u_dec (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (s_byte),
      .emit    (emit),
      .result  (result)
   );

   u8d_out_stage u_out (
      .clock          (clock),
      .reset          (reset),
      .s_valid        (s_valid),
      .emit           (emit),
      .result         (result),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_seq_length (rsp_seq_length),
      .rsp_replaced   (rsp_replaced)
   );

   a_replaced_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_replaced) |->
         (rsp_code_point == CP_REPLACEMENT) && (rsp_seq_length == LEN_ONE))
      else $error("replacement result malformed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && s_valid))
      else $error("input stalled without a blocked result");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_seq_length >= LEN_ONE) && (rsp_seq_length <= LEN_FOUR))
      else $error("result length out of range");

endmodule

### test/tb_utf8_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_core
// Self-checking bench for the UTF-8 stream decoder. A short directed table
// hits the lead-byte classes, the extreme code points, invalid leads and
// broken continuations. Random UTF-8 text with some noise follows. Each
// byte is run through a local decode model and every result is compared
// field by field. Sender gaps and receiver stalls vary from phase to phase,
// and one long receiver hold backs the decoder up to its input.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_core;
   import u8d_pkg::*;

   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int RESET_CYCLES = 5;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASE_ITEMS  = 150;
   localparam int PRESS_ITEMS  = 40;
   localparam int NUM_ROWS     = 25;
   localparam int NUM_PHASES   = 4;

   localparam result_type NO_RESULT = '0;
   localparam result_type REPL_CHAR = {CP_REPLACEMENT, LEN_ONE, 1'b1};

   typedef enum logic [1:0] {
      ROW_NONE,   // byte is expected to give no result
      ROW_TYPED,  // result is written in the table
      ROW_MODEL   // result comes from decode_byte
   } row_kind_type;

   typedef struct {
      logic [BYTE_W-1:0] b;
      row_kind_type      kind;
      result_type        want;
   } stim_row_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_in_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [CP_W-1:0]     rsp_code_point;
   logic [LEN_W-1:0]    rsp_seq_length;
   logic                rsp_replaced;

   // decoder model state
   logic [PEND_W-1:0]   conts_left = '0;
   logic [CP_W-1:0]     cp_accum   = '0;
   logic [LEN_W-1:0]    char_len   = LEN_ONE;

   result_type          expected_cps[$];
   int                  err_count     = 0;
   int                  bytes_sent    = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct     = 0;
   int                  hold_asked    = 0;
   int                  hold_taken    = 0;
   int                  hold_left     = 0;

   int phase_idle[NUM_PHASES]  = '{0, 83, 0, 11};
   int phase_stall[NUM_PHASES] = '{0, 0, 83, 11};

   stim_row_type dir_rows[NUM_ROWS] = '{
      '{8'h00, ROW_TYPED, {21'h000000, LEN_ONE, 1'b0}},
      '{8'h7F, ROW_TYPED, {21'h00007F, LEN_ONE, 1'b0}},
      '{8'h80, ROW_TYPED, REPL_CHAR},
      '{8'hBF, ROW_TYPED, REPL_CHAR},
      '{8'hC0, ROW_TYPED, REPL_CHAR},
      '{8'hC1, ROW_TYPED, REPL_CHAR},
      '{8'hF5, ROW_TYPED, REPL_CHAR},
      '{8'hFF, ROW_TYPED, REPL_CHAR},
      '{8'hC2, ROW_NONE,  NO_RESULT},
      '{8'h80, ROW_MODEL, NO_RESULT},
      '{8'hDF, ROW_NONE,  NO_RESULT},
      '{8'hBF, ROW_TYPED, {21'h0007FF, LEN_TWO, 1'b0}},
      '{8'hE0, ROW_NONE,  NO_RESULT},   // overlong three-byte form
      '{8'h80, ROW_NONE,  NO_RESULT},
      '{8'h80, ROW_MODEL, NO_RESULT},
      '{8'hEF, ROW_NONE,  NO_RESULT},
      '{8'hBF, ROW_NONE,  NO_RESULT},
      '{8'hBF, ROW_TYPED, {21'h00FFFF, LEN_THREE, 1'b0}},
      '{8'hF4, ROW_NONE,  NO_RESULT},   // largest four-byte value
      '{8'hBF, ROW_NONE,  NO_RESULT},
      '{8'hBF, ROW_NONE,  NO_RESULT},
      '{8'hBF, ROW_TYPED, {21'h13FFFF, LEN_FOUR, 1'b0}},
      '{8'hE1, ROW_NONE,  NO_RESULT},   // ASCII and a lead taken as continuations
      '{8'h41, ROW_NONE,  NO_RESULT},
      '{8'hC3, ROW_MODEL, NO_RESULT}
   };

   utf8_stream_decoder_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_seq_length (rsp_seq_length),
      .rsp_replaced   (rsp_replaced)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advances the model by one byte; returns 1 when a code point completes.
   function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output result_type r);
      r = NO_RESULT;
      if (conts_left != 0) begin
         cp_accum   = {cp_accum[CP_W-7:0], b[5:0]};
         conts_left = conts_left - 1'b1;
         if (conts_left != 0)
            return 1'b0;
         r = {cp_accum, char_len, 1'b0};
         return 1'b1;
      end
      if (b < 8'h80) begin
         char_len = LEN_ONE;
         cp_accum = '0;
         r = {CP_W'(b), LEN_ONE, 1'b0};
         return 1'b1;
      end
      if (b >= 8'hC2 && b <= 8'hDF) begin
         cp_accum   = CP_W'(b[4:0]);
         conts_left = 2'd1;
         char_len   = LEN_TWO;
         return 1'b0;
      end
      if (b >= 8'hE0 && b <= 8'hEF) begin
         cp_accum   = CP_W'(b[3:0]);
         conts_left = 2'd2;
         char_len   = LEN_THREE;
         return 1'b0;
      end
      if (b >= 8'hF0 && b <= 8'hF4) begin
         cp_accum   = CP_W'(b[2:0]);
         conts_left = 2'd3;
         char_len   = LEN_FOUR;
         return 1'b0;
      end
      char_len = LEN_ONE;
      cp_accum = '0;
      r = REPL_CHAR;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   // Offers one byte, with random gaps first, and returns once it is taken.
   task automatic drive_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      result_type r;
      drive_byte(b);
      if (decode_byte(b, r))
         expected_cps.push_back(r);
   endtask

   // Mostly proper continuations, now and then any byte at all.
   task automatic send_cont();
      if ($urandom_range(0, 99) < 8)
         send_byte(BYTE_W'($urandom_range(0, 255)));
      else
         send_byte(BYTE_W'($urandom_range(8'h80, 8'hBF)));
   endtask

   task automatic send_random_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         send_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 35) begin
         send_byte(BYTE_W'($urandom_range(0, 8'h7F)));
      end else if (pick < 60) begin
         send_byte(BYTE_W'($urandom_range(8'hC2, 8'hDF)));
         send_cont();
      end else if (pick < 80) begin
         send_byte(BYTE_W'($urandom_range(8'hE0, 8'hEF)));
         repeat (2) send_cont();
      end else begin
         send_byte(BYTE_W'($urandom_range(8'hF0, 8'hF4)));
         repeat (3) send_cont();
      end
   endtask

   // Receiver: random stall, or a long hold when one is asked for.
   always @(posedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_taken <= hold_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cps.size() == 0) begin
            report_mismatch($sformatf("unexpected item cp %h len %0d rep %0b",
                                      rsp_code_point, rsp_seq_length, rsp_replaced));
         end else begin
            want = expected_cps.pop_front();
            if (rsp_code_point !== want.code_point)
               report_mismatch($sformatf("code_point got %h want %h",
                                         rsp_code_point, want.code_point));
            if (rsp_seq_length !== want.seq_length)
               report_mismatch($sformatf("seq_length got %0d want %0d",
                                         rsp_seq_length, want.seq_length));
            if (rsp_replaced !== want.replaced)
               report_mismatch($sformatf("replaced got %0b want %0b",
                                         rsp_replaced, want.replaced));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout, %0d items still expected", expected_cps.size());
      $display("tb_utf8_stream_decoder_core failed");
      $finish;
   end

   initial begin : stimulus
      result_type r;
      bit         got;
      int         target;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         drive_byte(dir_rows[i].b);
         got = decode_byte(dir_rows[i].b, r);
         case (dir_rows[i].kind)
            ROW_TYPED: expected_cps.push_back(dir_rows[i].want);
            ROW_MODEL: if (got) expected_cps.push_back(r);
            default: ;
         endcase
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct = phase_idle[p];
         stall_pct     = phase_stall[p];
         target        = bytes_sent + PHASE_ITEMS;
         while (bytes_sent < target)
            send_random_char();

         // long receiver hold while bytes keep coming, so the input backs up
         if (p == 0) begin
            hold_asked <= hold_asked + 1;
            target = bytes_sent + PRESS_ITEMS;
            while (bytes_sent < target)
               send_random_char();
         end
      end

      req_valid <= 1'b0;
      while (expected_cps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0)
         $display("tb_utf8_stream_decoder_core passed");
      else
         $display("tb_utf8_stream_decoder_core failed");
      $finish;
   end

endmodule

### files.f
hdl/u8d_pkg.sv
hdl/u8d_in_stage.sv
hdl/u8d_decode.sv
hdl/u8d_out_stage.sv
hdl/utf8_stream_decoder_core.sv
test/tb_utf8_stream_decoder_core.sv
